### design/rpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpst_pkg
// Shared types and constants for the refcounted palette slot table.
// ----------------------------------------------------------------------------
package rpst_pkg;

  localparam int TYPE_W     = 8;
  localparam int TAG_W      = 16;
  localparam int REFS_W     = 8;
  localparam int SLOT_W     = 8;
  localparam int OP_W       = 3;
  localparam int CLR_FIRST_W = 4;
  localparam int CLR_SPAN_W = 5;

  localparam logic [SLOT_W-1:0] NO_SLOT = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE    = 3'd0,
    OP_FIND       = 3'd1,
    OP_ADD        = 3'd2,
    OP_INCREMENT  = 3'd3,
    OP_RELEASE    = 3'd4,
    OP_CLEAR_ALL  = 3'd5,
    OP_READ_TYPE  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_COMMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic [TAG_W-1:0]  tag;
    logic [REFS_W-1:0] refs;
  } entry_t;

  typedef struct packed {
    logic load;      // latch the input word
    logic rd_scan;   // read table at scan pointer, advance pointer
    logic rd_point;  // read table at addressed slot
    logic commit;    // write back and register the result word
  } cmd_t;

  typedef struct packed {
    logic scan_op;   // acquire, find or add
    logic point_op;  // increment, release or read type with index in range
    logic scan_last; // scan pointer at last slot
  } status_t;

endpackage

### design/rpst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpst_ctrl
// Sequencer for the slot table: accept, dispatch, scan or fetch where needed, commit, respond.
// ----------------------------------------------------------------------------
module rpst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rpst_pkg::status_t status,
  output rpst_pkg::cmd_t    cmd
);
  import rpst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (status.scan_op)       state_next = ST_SCAN;
        else if (status.point_op) state_next = ST_FETCH;
        else                      state_next = ST_COMMIT;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_COMMIT;
      ST_FETCH:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_RESP;
      ST_RESP: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.rd_scan  = 1'b1;
      ST_FETCH:  cmd.rd_point = 1'b1;
      ST_COMMIT: cmd.commit   = 1'b1;
      ST_RESP:   out_valid    = 1'b1;
      default: ;
    endcase
  end

endmodule

### design/rpst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpst_datapath
// Slot table memory, scan compare, read-modify-write and result register.
// ----------------------------------------------------------------------------
module rpst_datapath #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rpst_pkg::cmd_t                      cmd,
  output rpst_pkg::status_t                   status,
  input  logic [rpst_pkg::OP_W-1:0]           opcode,
  input  logic [rpst_pkg::TYPE_W-1:0]         entry_type,
  input  logic [rpst_pkg::TAG_W-1:0]          tag,
  input  logic [rpst_pkg::SLOT_W-1:0]         slot_index,
  output logic [rpst_pkg::SLOT_W-1:0]         slot,
  output logic [rpst_pkg::TYPE_W-1:0]         type_read,
  output logic                                clear_request,
  output logic [rpst_pkg::CLR_FIRST_W-1:0]    clear_first,
  output logic [rpst_pkg::CLR_SPAN_W-1:0]     clear_span
);
  import rpst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0]     SLOT_LIMIT = SLOT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CLR_SPAN_W-1:0] ALL_SPAN   = CLR_SPAN_W'(SLOT_COUNT);

  // latched input word
  logic [OP_W-1:0]   op_q;
  logic [TYPE_W-1:0] type_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SLOT_W-1:0] idx_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      type_q <= entry_type;
      tag_q  <= tag;
      idx_q  <= slot_index;
    end
  end

  logic             idx_ok;
  logic [IDX_W-1:0] idx_a;
  op_t              op;

  assign idx_ok = idx_q < SLOT_LIMIT;
  assign idx_a  = idx_q[IDX_W-1:0];
  assign op     = op_t'(op_q);

  // table storage; valid bits stand in for the reset/clear-all value of zero
  entry_t            mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  entry_t            rd_data;
  logic              rd_valid;
  entry_t            cur;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  scan_addr;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              clr_all;

  assign rd_addr = cmd.rd_scan ? scan_addr : idx_a;

  always_ff @(posedge clk) begin
    if (cmd.rd_scan || cmd.rd_point) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  assign cur = rd_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && clr_all) begin
      valid <= '0;
    end else if (cmd.commit && wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // scan: one read per cycle, compare in the next cycle
  logic             cmp_en;
  logic [IDX_W-1:0] cmp_idx;
  logic             match_hit;
  logic [IDX_W-1:0] match_idx;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic             cur_match;
  logic             cur_free;

  assign cur_match = (cur.etype == type_q) && (cur.tag == tag_q);
  assign cur_free  = (cur.etype == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_addr <= '0;
    end else if (cmd.rd_scan) begin
      scan_addr <= scan_addr + 1'b1;
    end
    cmp_idx <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en    <= 1'b0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_scan;
      if (cmd.load) begin
        match_hit <= 1'b0;
        free_hit  <= 1'b0;
      end else if (cmp_en) begin
        // keep the lowest hit of each kind
        if (!match_hit && cur_match) begin
          match_hit <= 1'b1;
          match_idx <= cmp_idx;
        end
        if (!free_hit && cur_free) begin
          free_hit <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
    end
  end

  assign status.scan_op   = (op == OP_ACQUIRE) || (op == OP_FIND) || (op == OP_ADD);
  assign status.point_op  = idx_ok &&
                            ((op == OP_INCREMENT) || (op == OP_RELEASE) ||
                             (op == OP_READ_TYPE));
  assign status.scan_last = (scan_addr == LAST_IDX);

  // commit: write-back and result word
  logic [SLOT_W-1:0]      res_slot;
  logic [TYPE_W-1:0]      res_type;
  logic                   res_creq;
  logic [CLR_FIRST_W-1:0] res_first;
  logic [CLR_SPAN_W-1:0]  res_span;
  logic [REFS_W-1:0]      rel_refs;
  entry_t                 claim;

  assign claim = '{etype: type_q, tag: tag_q, refs: '0};

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = idx_a;
    wr_data   = cur;
    clr_all   = 1'b0;
    res_slot  = NO_SLOT;
    res_type  = '0;
    res_creq  = 1'b0;
    res_first = '0;
    res_span  = '0;
    rel_refs  = (cur.refs != '0) ? cur.refs - 1'b1 : cur.refs;
    case (op)
      OP_ACQUIRE: begin
        if (match_hit) begin
          res_slot = SLOT_W'(match_idx);
        end else if (free_hit) begin
          res_slot = SLOT_W'(free_idx);
          wr_en    = 1'b1;
          wr_addr  = free_idx;
          wr_data  = claim;
        end
      end
      OP_FIND: begin
        if (match_hit) res_slot = SLOT_W'(match_idx);
      end
      OP_ADD: begin
        if (free_hit) begin
          res_slot = SLOT_W'(free_idx);
          wr_en    = 1'b1;
          wr_addr  = free_idx;
          wr_data  = claim;
        end
      end
      OP_INCREMENT: begin
        if (idx_ok) begin
          res_slot     = idx_q;
          wr_en        = 1'b1;
          wr_data.refs = cur.refs + 1'b1;
        end
      end
      OP_RELEASE: begin
        if (idx_ok) begin
          res_slot = idx_q;
          if (cur.etype == '0) begin
            // unused slot: clear request only, no update
            res_creq = 1'b1;
          end else begin
            wr_en        = 1'b1;
            wr_data.refs = rel_refs;
            if (rel_refs == '0) begin
              wr_data.etype = '0;
              res_creq      = 1'b1;
            end
          end
          if (res_creq) begin
            res_first = idx_q[CLR_FIRST_W-1:0];
            res_span  = CLR_SPAN_W'(1);
          end
        end
      end
      OP_CLEAR_ALL: begin
        clr_all  = 1'b1;
        res_creq = 1'b1;
        res_span = ALL_SPAN;
      end
      OP_READ_TYPE: begin
        if (idx_ok) begin
          res_slot = idx_q;
          res_type = cur.etype;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot          <= res_slot;
      type_read     <= res_type;
      clear_request <= res_creq;
      clear_first   <= res_first;
      clear_span    <= res_span;
    end
  end

endmodule

### design/refcounted_palette_slot_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_palette_slot_table_core
// Reference-counted palette slot table: acquire, find, add, increment,
// release, clear all and read type over SLOT_COUNT slots.
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | opcode, entry_type, tag, slot_index
//  out     | out_valid/out_ready| slot, type_read, clear_request,
//          |                    | clear_first, clear_span
//
//  One word at a time. Each accepted word is dispatched; acquire/find/add
//  then scan the slot memory (one table read per cycle) and drain, while
//  in-range increment/release/read type fetch their slot; every word then
//  commits; in_ready returns in the cycle right after the result is taken.
//  Reset clears the table through per-slot valid bits; no clearing pass.
//  A stalled result holds the block; nothing else is accepted meanwhile.
// ----------------------------------------------------------------------------
module refcounted_palette_slot_table_core #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rpst_pkg::OP_W-1:0]         opcode,
  input  logic [rpst_pkg::TYPE_W-1:0]       entry_type,
  input  logic [rpst_pkg::TAG_W-1:0]        tag,
  input  logic [rpst_pkg::SLOT_W-1:0]       slot_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rpst_pkg::SLOT_W-1:0]       slot,
  output logic [rpst_pkg::TYPE_W-1:0]       type_read,
  output logic                              clear_request,
  output logic [rpst_pkg::CLR_FIRST_W-1:0]  clear_first,
  output logic [rpst_pkg::CLR_SPAN_W-1:0]   clear_span
);
  import rpst_pkg::*;

  cmd_t    cmd;
  status_t status;

  rpst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rpst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (opcode),
    .entry_type    (entry_type),
    .tag           (tag),
    .slot_index    (slot_index),
    .slot          (slot),
    .type_read     (type_read),
    .clear_request (clear_request),
    .clear_first   (clear_first),
    .clear_span    (clear_span)
  );

  // input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  // a commit is followed by a result word
  a_commit_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit not followed by out_valid");

  // an accepted word never shows a result in the next cycle
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result right after accept");

  // a single-slot clear carries a span of one; a full clear starts at zero
  a_clear_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_request && clear_span != 5'd1) |-> (clear_first == '0))
    else $error("bad clear request shape");

endmodule
